// File: hdl/vwwb_pkg.sv
// shared constants, types and helpers of the vertex wind weight bake block
`timescale 1ns / 1ps

package vwwb_pkg;

  // table geometry
  localparam int MAX_NODES  = 4096;
  localparam int DEPTH_BITS = 8;
  localparam int NODE_AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  // q0.16 values run 0..1.0 inclusive, so they need 17 bits
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int Q_WIDE    = 20;
  localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

  // divider operand widths: dividend up to world_z * 10, divisor tree height
  localparam int DIV_AW = 35;
  localparam int DIV_DW = 32;

  // multiplier operand and product widths
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // 3.0 in q0.16, for the smoothstep term
  localparam logic [MUL_W-1:0] SMOOTH_K = 18'd196608;

  localparam logic [DEPTH_BITS-1:0] DEPTH_FLOOR   = DEPTH_BITS'(4);
  localparam logic [31:0]           TREE_H_RESET  = 32'd65536;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_VERTEX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_D,
    ST_DIV_T,
    ST_CALC,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    MS_T2,
    MS_S,
    MS_OO,
    MS_TRUNK,
    MS_D2,
    MS_BRANCH,
    MS_TWIG,
    MS_LEAF
  } mul_step_t;

  typedef struct packed {
    logic                  en;
    logic [NODE_AW-1:0]    addr;
    logic [DEPTH_BITS-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              start;
    logic [DIV_AW-1:0] a;
    logic [DIV_DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] d;
    logic [Q_W-1:0] t;
  } calc_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] trunk;
    logic [7:0] branch;
    logic [7:0] twig;
    logic [7:0] leaf;
  } calc_rsp_t;

  function automatic logic [Q_W-1:0] clamp_one(input logic [Q_WIDE-1:0] v);
    return (v > Q_WIDE'(Q_ONE)) ? Q_ONE : v[Q_W-1:0];
  endfunction

  // w * 255 / 65536, round half up
  function automatic logic [7:0] to_byte(input logic [Q_W-1:0] w);
    logic [24:0] acc;
    acc = {w, 8'b0} - 25'(w) + 25'd32768;
    return acc[23:16];
  endfunction

endpackage

// File: hdl/vertex_wind_weight_bake_top.sv
// top level of the vertex wind weight bake block
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  in_     | request   | in_valid / in_stall | req_type, node_index, node_depth, world_z
//  out_    | result    | out_valid/out_stall | trunk, branch, twig, leaf weights
//  cfg_    | write     | cfg_we              | cfg_wdata = tree_height
//
//  a load request: table write and max-depth update at the accept edge
//  a vertex request runs from accept to the next accept through one table read,
//    two runs of the serial divider and the products of the shared multiplier,
//    then ST_OUT and back to ST_IDLE
//  the output register parts the sides: a new request is taken while a result waits
//  reset returns control to idle, the max depth to 4 and tree_height to one metre;
//    the table is not cleared
//  a stalled result holds the finished item in ST_OUT until the register frees up

module vertex_wind_weight_bake_top
  import vwwb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [11:0]        in_node_index,
  input  logic [7:0]         in_node_depth,
  input  logic signed [31:0] in_world_z,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_trunk_weight,
  output logic [7:0]         out_branch_weight,
  output logic [7:0]         out_twig_weight,
  output logic [7:0]         out_leaf_weight,
  // configuration
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  logic [31:0]           tree_height_r;
  logic [DEPTH_BITS-1:0] deepest_level_r;
  logic                  in_range_r;
  logic signed [31:0]    z_r;
  logic [Q_W-1:0]        d_r;

  logic out_valid_r;
  logic [7:0] trunk_r, branch_r, twig_r, leaf_r;

  logic                  in_acc;
  logic                  in_range;
  logic [DEPTH_BITS-1:0] new_depth;
  logic [DEPTH_BITS-1:0] rd_depth;
  logic [DEPTH_BITS-1:0] node_depth;
  logic [DIV_AW-1:0]     z_abs;
  logic [DIV_AW-1:0]     z_times10;
  logic                  z_pos;
  logic                  out_load;

  mem_wr_t   mem_wr;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  calc_req_t calc_req;
  calc_rsp_t calc_rsp;

  // request side
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = int'(in_node_index) < MAX_NODES;
  assign new_depth = DEPTH_BITS'(in_node_depth);

  // in-range load requests write the table at the accept edge
  assign mem_wr.en   = in_acc && (in_req_type == REQ_LOAD) && in_range;
  assign mem_wr.addr = NODE_AW'(in_node_index);
  assign mem_wr.data = new_depth;

  vwwb_depth_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (NODE_AW'(in_node_index)),
    .rdata (rd_depth)
  );

  // indexes past the table read as depth zero
  assign node_depth = in_range_r ? rd_depth : '0;

  // world_z * 10, zero for heights at or below ground
  assign z_pos     = !z_r[31] && (z_r != 32'sd0);
  assign z_abs     = z_pos ? DIV_AW'(z_r[30:0]) : '0;
  assign z_times10 = (z_abs << 3) + (z_abs << 1);

  vwwb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  vwwb_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_req_type == REQ_VERTEX) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIV_D;
      end
      ST_DIV_D: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIV_T;
        end
      end
      ST_DIV_T: begin
        if (div_rsp.done) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // unit control
  always_comb begin
    div_req.start  = 1'b0;
    div_req.a      = z_times10;
    div_req.d      = (tree_height_r == 32'd0) ? 32'd1 : tree_height_r;
    calc_req.start = 1'b0;
    calc_req.d     = d_r;
    calc_req.t     = div_rsp.q;
    out_load       = 1'b0;
    case (state_r)
      ST_READ: begin
        // depth over the running max depth
        div_req.start = 1'b1;
        div_req.a     = DIV_AW'(node_depth);
        div_req.d     = (deepest_level_r == '0) ? DIV_DW'(1) : DIV_DW'(deepest_level_r);
      end
      ST_DIV_D: begin
        // height over tree height, times ten
        div_req.start = div_rsp.done;
      end
      ST_DIV_T: begin
        calc_req.start = div_rsp.done;
      end
      ST_OUT: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      tree_height_r   <= TREE_H_RESET;
      deepest_level_r <= DEPTH_FLOOR;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tree_height_r <= cfg_wdata;
      end
      // max depth only ever rises
      if (mem_wr.en && new_depth > deepest_level_r) begin
        deepest_level_r <= new_depth;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_range_r <= in_range;
      z_r        <= in_world_z;
    end
    if (state_r == ST_DIV_D && div_rsp.done) begin
      d_r <= div_rsp.q;
    end
    if (out_load) begin
      trunk_r  <= calc_rsp.trunk;
      branch_r <= calc_rsp.branch;
      twig_r   <= calc_rsp.twig;
      leaf_r   <= calc_rsp.leaf;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trunk_weight  = trunk_r;
  assign out_branch_weight = branch_r;
  assign out_twig_weight   = twig_r;
  assign out_leaf_weight   = leaf_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_D || state_r == ST_DIV_T))
    else $error("divider finished outside a divide state");

  a_calc_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    calc_rsp.done |-> (state_r == ST_CALC))
    else $error("weight sequencer finished outside the calc state");

  a_depth_floor: assert property (@(posedge clk) disable iff (!rst_n)
    deepest_level_r >= DEPTH_FLOOR)
    else $error("max depth fell below its floor");

  a_vertex_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == REQ_VERTEX) |=> (state_r == ST_READ))
    else $error("vertex request did not start a table read");
`endif

endmodule

// File: hdl/vwwb_depth_mem.sv
// node depth table: single write port, registered read port
`timescale 1ns / 1ps

module vwwb_depth_mem
  import vwwb_pkg::*;
(
  input  logic                  clk,
  input  mem_wr_t               wr,
  input  logic [NODE_AW-1:0]    raddr,
  output logic [DEPTH_BITS-1:0] rdata
);

  logic [DEPTH_BITS-1:0] mem [MAX_NODES];
  logic [DEPTH_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/vwwb_div.sv
// serial q0.16 divider with clamp to 1.0, one quotient bit per cycle
`timescale 1ns / 1ps

module vwwb_div
  import vwwb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic                 busy_r;
  logic                 done_r;
  logic                 sat_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_DW-1:0]    rem_r;
  logic [DIV_DW-1:0]    dvs_r;
  logic [FRAC_BITS-1:0] quo_r;

  logic [DIV_DW:0] shifted;
  logic [DIV_DW:0] diff;
  logic            ge;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // integer part of one or more means the quotient clamps to 1.0
  always_ff @(posedge clk) begin
    if (req.start) begin
      sat_r <= req.a >= DIV_AW'(req.d);
      rem_r <= req.a[DIV_DW-1:0];
      dvs_r <= req.d;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      quo_r <= {quo_r[FRAC_BITS-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = sat_r ? Q_ONE : {1'b0, quo_r};

endmodule

// File: hdl/vwwb_calc.sv
// weight sequencer: eight q0.16 products through one shared multiplier
`timescale 1ns / 1ps

module vwwb_calc
  import vwwb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  calc_req_t req,
  output calc_rsp_t rsp
);

  logic      busy_r;
  logic      wb_r;
  logic      done_r;
  mul_step_t step_r;
  mul_step_t step_nxt;

  logic [Q_W-1:0] t_r, d_r, om_r, t2_r, s_r, oo_r, d2_r;
  logic [Q_W-1:0] trunk_r, branch_r, twig_r, leaf_r;
  logic [PROD_W-1:0] prod_r;

  logic [MUL_W-1:0]  op_a;
  logic [MUL_W-1:0]  op_b;
  logic [Q_WIDE-1:0] wb_raw;
  logic [Q_W-1:0]    wb_val;

  // operand select and step order
  always_comb begin
    op_a     = MUL_W'(t_r);
    op_b     = MUL_W'(t_r);
    step_nxt = MS_LEAF;
    case (step_r)
      MS_T2: begin
        op_a = MUL_W'(t_r);   op_b = MUL_W'(t_r);   step_nxt = MS_S;
      end
      MS_S: begin
        op_a = MUL_W'(t2_r);  op_b = SMOOTH_K - {t_r, 1'b0}; step_nxt = MS_OO;
      end
      MS_OO: begin
        op_a = MUL_W'(om_r);  op_b = MUL_W'(om_r);  step_nxt = MS_TRUNK;
      end
      MS_TRUNK: begin
        op_a = MUL_W'(oo_r);  op_b = MUL_W'(s_r);   step_nxt = MS_D2;
      end
      MS_D2: begin
        op_a = MUL_W'(d_r);   op_b = MUL_W'(d_r);   step_nxt = MS_BRANCH;
      end
      MS_BRANCH: begin
        op_a = MUL_W'(d_r);   op_b = MUL_W'(om_r);  step_nxt = MS_TWIG;
      end
      MS_TWIG: begin
        op_a = MUL_W'(d2_r);  op_b = MUL_W'(om_r);  step_nxt = MS_LEAF;
      end
      MS_LEAF: begin
        op_a = MUL_W'(d2_r);  op_b = MUL_W'(d_r);   step_nxt = MS_LEAF;
      end
      default: begin
        op_a = MUL_W'(t_r);   op_b = MUL_W'(t_r);   step_nxt = MS_LEAF;
      end
    endcase
  end

  // branch and twig carry the factor of four
  assign wb_raw = (step_r == MS_BRANCH || step_r == MS_TWIG) ? prod_r[33:14] : prod_r[35:16];
  assign wb_val = clamp_one(wb_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wb_r   <= 1'b0;
      done_r <= 1'b0;
      step_r <= MS_T2;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        wb_r   <= 1'b0;
        step_r <= MS_T2;
      end else if (busy_r) begin
        wb_r <= !wb_r;
        if (wb_r) begin
          if (step_r == MS_LEAF) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            step_r <= step_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      t_r  <= req.t;
      d_r  <= req.d;
      om_r <= Q_ONE - req.d;
    end else if (busy_r && !wb_r) begin
      prod_r <= op_a * op_b;
    end else if (busy_r && wb_r) begin
      case (step_r)
        MS_T2:     t2_r     <= wb_val;
        MS_S:      s_r      <= wb_val;
        MS_OO:     oo_r     <= wb_val;
        MS_TRUNK:  trunk_r  <= wb_val;
        MS_D2:     d2_r     <= wb_val;
        MS_BRANCH: branch_r <= wb_val;
        MS_TWIG:   twig_r   <= wb_val;
        MS_LEAF:   leaf_r   <= wb_val;
        default:   leaf_r   <= wb_val;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.trunk  = to_byte(trunk_r);
  assign rsp.branch = to_byte(branch_r);
  assign rsp.twig   = to_byte(twig_r);
  assign rsp.leaf   = to_byte(leaf_r);

endmodule
